// ===== src/ents_pkg.sv =====
// ----------------------------------------------------------------------------
// ents_pkg : shared types, constants and microcode for the e^-x series core
// Field widths, saturation limits, sequencer control word layout and the
// control program ROM that steps the datapath through one request.
// ----------------------------------------------------------------------------
package ents_pkg;

  // Default configuration
  localparam int MAX_TERMS_DEF = 1023;
  localparam int FRAC_BITS_DEF = 32;

  // Fixed field widths
  localparam int X_W    = 21;              // x argument, Q4.16
  localparam int X_FRAC = 16;
  localparam int TC_W   = 10;              // term count
  localparam int N_W    = TC_W + 1;        // term index, reaches N+1
  localparam int OUT_W  = 48;
  localparam int MAG_W  = OUT_W - 1;       // term magnitude
  localparam int LO_W   = 24;              // low slice of the term for the multiplier
  localparam int HI_W   = MAG_W - LO_W;
  localparam int PH_W   = HI_W + X_W;
  localparam int PL_W   = LO_W + X_W;
  localparam int PROD_W = MAG_W + X_W;
  localparam int DVD_W  = PROD_W - X_FRAC; // dividend after the 2^16 scale

  localparam logic signed [OUT_W-1:0] POS_LIM = {1'b0, {MAG_W{1'b1}}};
  localparam logic signed [OUT_W-1:0] NEG_LIM = {1'b1, {MAG_W{1'b0}}};

  // Datapath operations
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP        = 4'd0;
  localparam op_t OP_LOAD       = 4'd1;
  localparam op_t OP_MUL_HI     = 4'd2;
  localparam op_t OP_MUL_LO     = 4'd3;
  localparam op_t OP_DIV_INIT   = 4'd4;
  localparam op_t OP_DIV_STEP   = 4'd5;
  localparam op_t OP_ACCUM      = 4'd6;
  localparam op_t OP_FINISH     = 4'd7;
  localparam op_t OP_RECIP_STEP = 4'd8;
  localparam op_t OP_OUTPUT     = 4'd9;

  // Jump conditions
  typedef logic [2:0] cond_t;
  localparam cond_t COND_NEVER      = 3'd0;
  localparam cond_t COND_ALWAYS     = 3'd1;
  localparam cond_t COND_NO_START   = 3'd2;
  localparam cond_t COND_LOOP_DONE  = 3'd3;
  localparam cond_t COND_CNT_MORE   = 3'd4;
  localparam cond_t COND_SKIP_RECIP = 3'd5;

  // Program steps
  typedef logic [3:0] pc_t;
  localparam pc_t STEP_IDLE  = 4'd0;
  localparam pc_t STEP_CHECK = 4'd1;
  localparam pc_t STEP_MULH  = 4'd2;
  localparam pc_t STEP_MULL  = 4'd3;
  localparam pc_t STEP_DIVI  = 4'd4;
  localparam pc_t STEP_DIVS  = 4'd5;
  localparam pc_t STEP_ACC   = 4'd6;
  localparam pc_t STEP_FIN   = 4'd7;
  localparam pc_t STEP_RCP   = 4'd8;
  localparam pc_t STEP_OUT   = 4'd9;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  typedef struct packed {
    logic loop_done;   // past the last term, or saturated
    logic cnt_more;    // iteration counter not yet on its last step
    logic skip_recip;  // no reciprocal pass needed
  } dp_status_t;

  // Control program ROM
  function automatic ctrl_word_t ucode(input pc_t pc);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (pc)
      STEP_IDLE:  w = '{op: OP_LOAD,       cond: COND_NO_START,   target: STEP_IDLE};
      STEP_CHECK: w = '{op: OP_NOP,        cond: COND_LOOP_DONE,  target: STEP_FIN};
      STEP_MULH:  w = '{op: OP_MUL_HI,     cond: COND_NEVER,      target: STEP_IDLE};
      STEP_MULL:  w = '{op: OP_MUL_LO,     cond: COND_NEVER,      target: STEP_IDLE};
      STEP_DIVI:  w = '{op: OP_DIV_INIT,   cond: COND_NEVER,      target: STEP_IDLE};
      STEP_DIVS:  w = '{op: OP_DIV_STEP,   cond: COND_CNT_MORE,   target: STEP_DIVS};
      STEP_ACC:   w = '{op: OP_ACCUM,      cond: COND_ALWAYS,     target: STEP_CHECK};
      STEP_FIN:   w = '{op: OP_FINISH,     cond: COND_SKIP_RECIP, target: STEP_OUT};
      STEP_RCP:   w = '{op: OP_RECIP_STEP, cond: COND_CNT_MORE,   target: STEP_RCP};
      STEP_OUT:   w = '{op: OP_OUTPUT,     cond: COND_ALWAYS,     target: STEP_IDLE};
      default:    w = '{op: OP_NOP,        cond: COND_ALWAYS,     target: STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== src/ents_sequencer.sv =====
// ----------------------------------------------------------------------------
// ents_sequencer : step counter and control ROM
// Fetches one control word per cycle and resolves conditional jumps.
// ----------------------------------------------------------------------------
module ents_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  ents_pkg::dp_status_t  status,
  output ents_pkg::ctrl_word_t  ctrl,
  output logic                  busy
);

  ents_pkg::pc_t pc;
  ents_pkg::pc_t pc_next;
  logic          take_jump;

  assign ctrl = ents_pkg::ucode(pc);
  assign busy = (pc != ents_pkg::STEP_IDLE);

  always_comb begin
    unique case (ctrl.cond)
      ents_pkg::COND_NEVER:      take_jump = 1'b0;
      ents_pkg::COND_ALWAYS:     take_jump = 1'b1;
      ents_pkg::COND_NO_START:   take_jump = !start;
      ents_pkg::COND_LOOP_DONE:  take_jump = status.loop_done;
      ents_pkg::COND_CNT_MORE:   take_jump = status.cnt_more;
      ents_pkg::COND_SKIP_RECIP: take_jump = status.skip_recip;
      default:                   take_jump = 1'b1;
    endcase
    pc_next = take_jump ? ctrl.target : pc + ents_pkg::pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ents_pkg::STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== src/ents_datapath.sv =====
// ----------------------------------------------------------------------------
// ents_datapath : registers and arithmetic for the series evaluation
// Split multiplier, bit-serial term divider, accumulator and bit-serial
// reciprocal, each driven by the current control word.
// ----------------------------------------------------------------------------
module ents_datapath #(
  parameter int MAX_TERMS = ents_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = ents_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  ents_pkg::ctrl_word_t                   ctrl,
  input  logic                                   mode,
  input  logic signed [ents_pkg::X_W-1:0]        x_value,
  input  logic        [ents_pkg::TC_W-1:0]       term_count,
  output ents_pkg::dp_status_t                   status,
  output logic signed [ents_pkg::OUT_W-1:0]      result_value,
  output logic                                   saturated
);

  localparam int X_W    = ents_pkg::X_W;
  localparam int TC_W   = ents_pkg::TC_W;
  localparam int N_W    = ents_pkg::N_W;
  localparam int OUT_W  = ents_pkg::OUT_W;
  localparam int MAG_W  = ents_pkg::MAG_W;
  localparam int LO_W   = ents_pkg::LO_W;
  localparam int PH_W   = ents_pkg::PH_W;
  localparam int PL_W   = ents_pkg::PL_W;
  localparam int PROD_W = ents_pkg::PROD_W;
  localparam int DVD_W  = ents_pkg::DVD_W;
  localparam int RCP_STEPS = 2 * FRAC_BITS + 1;
  localparam int CNT_MAX   = (RCP_STEPS > DVD_W) ? RCP_STEPS : DVD_W;
  localparam int CNT_W     = $clog2(CNT_MAX + 1);

  // operands
  logic [X_W-1:0]   x_mag;
  logic             x_neg;
  logic [TC_W-1:0]  nmax;
  logic [N_W-1:0]   n;
  logic [MAG_W-1:0] term_mag;
  logic             term_neg;
  logic signed [OUT_W-1:0] sum;
  logic             sat;
  logic             dir_neg;
  // multiplier and divider
  logic [PH_W-1:0]  prod_hi;
  logic [PL_W-1:0]  prod_lo;
  logic [DVD_W-1:0] dvd;
  logic [TC_W-1:0]  rem;
  logic [CNT_W-1:0] cnt;
  // reciprocal
  logic [MAG_W-1:0] rcp_rem;
  logic [MAG_W-1:0] rcp_q;

  logic [X_W-1:0]    x_abs;
  logic [TC_W-1:0]   tc_clamp;
  logic [PROD_W-1:0] prod_full;
  logic [TC_W:0]     div_trial;
  logic              div_ge;
  logic [TC_W:0]     div_diff;
  logic              q_ovf;
  logic [MAG_W-1:0]  q_mag;
  logic              step_neg;
  logic [OUT_W:0]    acc_wide;
  logic              sum_ovf;
  logic              sum_le0;
  logic              rcp_bit;
  logic [OUT_W-1:0]  rcp_trial;
  logic              rcp_ge;
  logic [OUT_W-1:0]  rcp_diff;
  logic [OUT_W-1:0]  rcp_qn;
  logic signed [OUT_W-1:0] res_sel;

  always_comb begin
    x_abs     = x_value[X_W-1] ? (X_W'(~x_value) + X_W'(1)) : X_W'(x_value);
    tc_clamp  = (int'(term_count) > MAX_TERMS) ? TC_W'(MAX_TERMS) : term_count;
    prod_full = {prod_hi, {LO_W{1'b0}}} + PROD_W'(prod_lo);

    div_trial = {rem, dvd[DVD_W-1]};
    div_ge    = (div_trial >= {1'b0, n[TC_W-1:0]});
    div_diff  = div_trial - {1'b0, n[TC_W-1:0]};

    q_ovf    = |dvd[DVD_W-1:MAG_W];
    q_mag    = dvd[MAG_W-1:0];
    step_neg = term_neg ^ x_neg ^ !mode;
    acc_wide = {sum[OUT_W-1], sum} +
               (step_neg ? ((OUT_W+1)'(0) - {2'b00, q_mag}) : {2'b00, q_mag});
    sum_ovf  = (acc_wide[OUT_W] != acc_wide[OUT_W-1]);
    sum_le0  = sum[OUT_W-1] || (sum == '0);

    rcp_bit   = (cnt == CNT_W'(RCP_STEPS));
    rcp_trial = {rcp_rem, rcp_bit};
    rcp_ge    = (rcp_trial >= {1'b0, sum[MAG_W-1:0]});
    rcp_diff  = rcp_trial - {1'b0, sum[MAG_W-1:0]};
    rcp_qn    = {rcp_q, rcp_ge};

    if (!mode) begin
      res_sel = sat ? (dir_neg ? ents_pkg::NEG_LIM : ents_pkg::POS_LIM) : sum;
    end else if (sat) begin
      res_sel = dir_neg ? ents_pkg::POS_LIM : '0;
    end else begin
      res_sel = {1'b0, rcp_q};
    end

    status.loop_done  = (n > {1'b0, nmax}) || sat;
    status.cnt_more   = (cnt != CNT_W'(1));
    status.skip_recip = !mode || sat || sum_le0;
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      ents_pkg::OP_LOAD: begin
        x_mag    <= x_abs;
        x_neg    <= x_value[X_W-1];
        nmax     <= tc_clamp;
        n        <= N_W'(1);
        term_mag <= MAG_W'(1) << FRAC_BITS;
        term_neg <= 1'b0;
        sum      <= OUT_W'(1) << FRAC_BITS;
        sat      <= 1'b0;
        dir_neg  <= 1'b0;
      end
      ents_pkg::OP_MUL_HI: begin
        prod_hi <= term_mag[MAG_W-1:LO_W] * x_mag;
      end
      ents_pkg::OP_MUL_LO: begin
        prod_lo <= term_mag[LO_W-1:0] * x_mag;
      end
      ents_pkg::OP_DIV_INIT: begin
        // drop the 2^16 scale first; the remaining divisor is n
        dvd <= prod_full[PROD_W-1:ents_pkg::X_FRAC];
        rem <= '0;
        cnt <= CNT_W'(DVD_W);
      end
      ents_pkg::OP_DIV_STEP: begin
        rem <= div_ge ? div_diff[TC_W-1:0] : div_trial[TC_W-1:0];
        dvd <= {dvd[DVD_W-2:0], div_ge};
        cnt <= cnt - CNT_W'(1);
      end
      ents_pkg::OP_ACCUM: begin
        if (q_ovf) begin
          sat     <= 1'b1;
          dir_neg <= step_neg;
        end else begin
          term_mag <= q_mag;
          term_neg <= step_neg && (q_mag != '0);
          sum      <= acc_wide[OUT_W-1:0];
          if (sum_ovf) begin
            sat     <= 1'b1;
            dir_neg <= acc_wide[OUT_W];
          end
        end
        n <= n + N_W'(1);
      end
      ents_pkg::OP_FINISH: begin
        // a non-positive sum has no usable reciprocal: force the top limit
        if (mode && !sat && sum_le0) begin
          sat     <= 1'b1;
          dir_neg <= 1'b1;
        end
        rcp_rem <= '0;
        rcp_q   <= '0;
        cnt     <= CNT_W'(RCP_STEPS);
      end
      ents_pkg::OP_RECIP_STEP: begin
        if (!sat) begin
          rcp_rem <= rcp_ge ? rcp_diff[MAG_W-1:0] : rcp_trial[MAG_W-1:0];
          if (rcp_qn[OUT_W-1]) begin
            sat     <= 1'b1;
            dir_neg <= 1'b1;
          end else begin
            rcp_q <= rcp_qn[MAG_W-1:0];
          end
        end
        cnt <= cnt - CNT_W'(1);
      end
      ents_pkg::OP_OUTPUT: begin
        result_value <= res_sel;
        saturated    <= sat;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/exp_neg_taylor_series_core.sv =====
// ----------------------------------------------------------------------------
// exp_neg_taylor_series_core : truncated Taylor series for e^-x
// Evaluates e^-x for a signed Q4.16 argument as a fixed-point series with
// FRAC_BITS fraction bits in a 48-bit signed result, either directly as the
// alternating series or as the reciprocal of the e^x series.
// ----------------------------------------------------------------------------
//
//  channel   | signals                                   | flow
//  ----------+-------------------------------------------+---------------------
//  request   | start, busy, x_value, term_count          | in, taken on start & !busy
//  result    | result_valid, result_value, saturated     | out, one-cycle strobe
//  config    | cfg_valid, cfg_ready, series_mode         | in, taken on valid & ready
//
//  Sequence: one request at a time. Each term runs the check, the two
//  multiplier halves, the divider load, 52 divider steps and the accumulate;
//  the loop repeats for the clamped term count N, and mode 1 then adds
//  2*FRAC_BITS+1 reciprocal steps. Most of each term is spent in the
//  bit-serial term divider.
//  Reset: rst clears the step counter, the strobe and series_mode (0).
//  Stalls: none. busy stays high from the request until the strobe cycle,
//  in which a new request may already be taken.
//
module exp_neg_taylor_series_core #(
  parameter int MAX_TERMS = ents_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = ents_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ents_pkg::X_W-1:0]     x_value,
  input  logic        [ents_pkg::TC_W-1:0]    term_count,
  // configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                series_mode,
  // result channel
  output logic                                result_valid,
  output logic signed [ents_pkg::OUT_W-1:0]   result_value,
  output logic                                saturated
);

  ents_pkg::ctrl_word_t ctrl;
  ents_pkg::dp_status_t status;
  logic                 mode;

  // Mode register: write only between requests.
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      mode <= series_mode;
    end
  end

  // Sequencer: the idle step loads the operands every cycle and holds until
  // start; the step after the accepting edge begins the term loop.
  ents_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  ents_datapath #(
    .MAX_TERMS (MAX_TERMS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .ctrl         (ctrl),
    .mode         (mode),
    .x_value      (x_value),
    .term_count   (term_count),
    .status       (status),
    .result_value (result_value),
    .saturated    (saturated)
  );

  // Strobe the result in the cycle after the output step, together with the value that step registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (ctrl.op == ents_pkg::OP_OUTPUT);
    end
  end

  // A result only follows a busy cycle.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe without a request in flight");

  // An accepted request makes the core busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request accepted but core not busy");

  // One strobe per request: never two in a row.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe lasted more than one cycle");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb : self-checking bench for exp_neg_taylor_series_core
// Sends requests of argument x and term count N over the start/busy
// handshake and checks every result strobe against a bit-exact scoreboard
// model. Both series modes are exercised: directed corners first, then
// random requests with varying sender gaps.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [ents_pkg::OUT_W-1:0] value;
  logic                              sat;
} exp_value_t;

localparam longint signed EXP_SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
localparam longint signed EXP_SUM_MIN = -EXP_SUM_MAX - 64'sd1;

// One series step: t * x / (n * 2^16), negated for the alternating series.
// The product is split at bit 24 so the divide keeps full precision.
// Returns 1 on overflow, with ovf_neg giving its sign.
function automatic bit next_series_term(input longint signed t, input longint signed x,
                                        input longint unsigned n, input bit negate,
                                        output longint signed nt, output bit ovf_neg);
  longint unsigned a, b, d, ah, al, p1, q1, r1, rem, q;
  bit neg;
  a = (t < 0) ? -t : t;
  b = (x < 0) ? -x : x;
  d = n << ents_pkg::X_FRAC;
  ah = a >> 24;
  al = a & 64'hFF_FFFF;
  p1 = ah * b;
  q1 = p1 / d;
  r1 = p1 % d;
  neg = ((t < 0) != (x < 0)) != negate;
  ovf_neg = neg;
  nt = 0;
  if (q1 >= (64'd1 << 23)) return 1'b1;
  rem = (r1 << 24) + al * b;
  q = (q1 << 24) + rem / d;
  if (q > EXP_SUM_MAX) return 1'b1;
  nt = neg ? -longint'(q) : longint'(q);
  return 1'b0;
endfunction

// Expected core output for one request under the given series mode.
function automatic exp_value_t predict_exp_neg(input bit recip_mode,
                                               input logic signed [ents_pkg::X_W-1:0] xv,
                                               input logic [ents_pkg::TC_W-1:0] tc);
  longint signed x, term, sum, nt, res;
  longint unsigned s, r, q, nmax, n;
  bit sat, dneg;
  int i;
  exp_value_t e;
  x = xv;
  nmax = tc;
  if (nmax > ents_pkg::MAX_TERMS_DEF) nmax = ents_pkg::MAX_TERMS_DEF;
  term = 64'sd1 << ents_pkg::FRAC_BITS_DEF;
  sum = term;
  sat = 1'b0;
  dneg = 1'b0;
  nt = 0;
  for (n = 1; n <= nmax && !sat; n++) begin
    if (next_series_term(term, x, n, !recip_mode, nt, dneg)) begin
      sat = 1'b1;
      break;
    end
    term = nt;
    sum += term;
    if (sum > EXP_SUM_MAX || sum < EXP_SUM_MIN) begin
      dneg = sum < 0;
      sat = 1'b1;
    end
  end
  if (!recip_mode) begin
    res = sat ? (dneg ? EXP_SUM_MIN : EXP_SUM_MAX) : sum;
  end else if (sat) begin
    res = dneg ? EXP_SUM_MAX : 64'sd0;
  end else if (sum <= 0) begin
    res = EXP_SUM_MAX;
    sat = 1'b1;
  end else begin
    // restoring divide of 2^(2*FRAC_BITS) by the sum
    s = sum;
    r = 0;
    q = 0;
    for (i = 2 * ents_pkg::FRAC_BITS_DEF; i >= 0; i--) begin
      r = (r << 1) | ((i == 2 * ents_pkg::FRAC_BITS_DEF) ? 64'd1 : 64'd0);
      q = q << 1;
      if (r >= s) begin
        r = r - s;
        q = q | 64'd1;
      end
      if (q > EXP_SUM_MAX) begin
        sat = 1'b1;
        break;
      end
    end
    res = sat ? EXP_SUM_MAX : longint'(q);
  end
  e.value = res[ents_pkg::OUT_W-1:0];
  e.sat = sat;
  return e;
endfunction

class exp_neg_scoreboard;
  exp_value_t expected_exp[$];
  bit         recip_mode;
  int         errors;
  int         results_checked;
  int         sat_seen;
  int         mode_requests[2];

  function void set_mode(bit m);
    recip_mode = m;
  endfunction

  function void note_request(logic signed [ents_pkg::X_W-1:0] x,
                             logic [ents_pkg::TC_W-1:0] n);
    expected_exp.push_back(predict_exp_neg(recip_mode, x, n));
    mode_requests[recip_mode]++;
  endfunction

  function void check_result(logic signed [ents_pkg::OUT_W-1:0] value, logic sat);
    exp_value_t want;
    if (expected_exp.size() == 0) begin
      errors++;
      $display("%0t: result with nothing outstanding: value %0d saturated %0b",
               $time, value, sat);
      return;
    end
    want = expected_exp.pop_front();
    results_checked++;
    if (value !== want.value) begin
      errors++;
      $display("%0t: result_value mismatch: expected %0d, actual %0d",
               $time, want.value, value);
    end
    if (sat !== want.sat) begin
      errors++;
      $display("%0t: saturated mismatch: expected %0b, actual %0b", $time, want.sat, sat);
    end
    if (want.sat) sat_seen++;
  endfunction

  function int outstanding();
    return expected_exp.size();
  endfunction
endclass

module tb;

  // The slowest request (1023 terms plus the reciprocal pass) runs with no
  // handshake at all for its whole length; the limit allows about four times that.
  localparam int QUIET_LIMIT = 250000;
  localparam int TAIL_CYCLES = 200;
  localparam int RAND_CHUNK  = 19;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               start = 1'b0;
  logic                               busy;
  logic signed [ents_pkg::X_W-1:0]    x_value = '0;
  logic        [ents_pkg::TC_W-1:0]   term_count = '0;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic                               series_mode = 1'b0;
  logic                               result_valid;
  logic signed [ents_pkg::OUT_W-1:0]  result_value;
  logic                               saturated;

  int quiet_cycles = 0;

  exp_neg_scoreboard scoreboard = new();

  exp_neg_taylor_series_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .x_value      (x_value),
    .term_count   (term_count),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .series_mode  (series_mode),
    .result_valid (result_valid),
    .result_value (result_value),
    .saturated    (saturated)
  );

  always #2 clk = ~clk;

  // Sample at the rising edge: every input was driven by a nonblocking
  // assignment and every output still holds its pre-edge value here.
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) scoreboard.check_result(result_value, saturated);
      if (start && !busy) scoreboard.note_request(x_value, term_count);
      if (cfg_valid && cfg_ready) scoreboard.set_mode(series_mode);
    end
  end

  // Watchdog: end the run when no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired after %0d quiet cycles", $time, quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Issue one request. Hold start low for a random gap first, then hold the
  // request until the edge that takes it. Start is left high on return so a
  // back-to-back request never lowers and raises it in one time step.
  task automatic send_request(input logic signed [ents_pkg::X_W-1:0] xv,
                              input logic [ents_pkg::TC_W-1:0] tc, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    x_value    <= xv;
    term_count <= tc;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Drop start and wait until every outstanding result has been checked.
  // Step one edge first so the sampler has noted the last request.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (scoreboard.outstanding() != 0) @(posedge clk);
  endtask

  // Write series_mode; only called with the core idle.
  task automatic write_mode(input logic m);
    cfg_valid   <= 1'b1;
    series_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Corner requests: zero terms, the full term count, argument extremes,
  // overflow both ways, a zero and a negative partial sum, and a positive
  // sum so small that its reciprocal overflows.
  task automatic run_corners();
    send_request(21'sd0, 10'd0, 0);
    send_request(21'sd0, 10'd1023, 0);
    send_request(21'sd65536, 10'd20, 0);
    send_request(-21'sd65536, 10'd20, 0);
    send_request(21'h0F_FFFF, 10'd30, 0);
    send_request(21'h10_0000, 10'd30, 0);
    send_request(21'sd131072, 10'd1, 0);
    send_request(-21'sd65536, 10'd1, 0);
    send_request(-21'sd131072, 10'd1, 0);
    send_request(-21'sd65535, 10'd1, 0);
    send_request(21'sd1, 10'd5, 0);
    send_request(-21'sd1, 10'd5, 0);
  endtask

  // Bias x toward arguments below 2 and term counts toward short series;
  // a few requests take the full range of either field.
  function automatic logic signed [ents_pkg::X_W-1:0] pick_x();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return ents_pkg::X_W'($urandom_range(262143) - 131072);
    if (sel < 70) return ents_pkg::X_W'($urandom_range(1048575) - 524288);
    return ents_pkg::X_W'($urandom);
  endfunction

  function automatic logic [ents_pkg::TC_W-1:0] pick_terms();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 88) return ents_pkg::TC_W'($urandom_range(24));
    if (sel < 97) return ents_pkg::TC_W'($urandom_range(80, 25));
    return ents_pkg::TC_W'($urandom_range(1023));
  endfunction

  initial begin
    int chunk_idle[4];
    bit chunk_mode[4];
    chunk_idle = '{9, 58, 0, 0};
    chunk_mode = '{1'b0, 1'b1, 1'b0, 1'b1};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed corners, first in the reset mode, then in the reciprocal mode.
    run_corners();
    drain_results();
    write_mode(1'b1);
    run_corners();
    drain_results();

    // Random requests: light sender gaps, heavy gaps, then none at all,
    // switching the series mode at each chunk boundary.
    for (int c = 0; c < 4; c++) begin
      write_mode(chunk_mode[c]);
      for (int k = 0; k < RAND_CHUNK; k++) send_request(pick_x(), pick_terms(), chunk_idle[c]);
      drain_results();
    end

    // Let a stray strobe show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d alternating series, %0d reciprocal series).",
             scoreboard.mode_requests[0] + scoreboard.mode_requests[1],
             scoreboard.mode_requests[0], scoreboard.mode_requests[1]);
    $display("Checked %0d results, %0d of them saturated; %0d errors.",
             scoreboard.results_checked, scoreboard.sat_seen, scoreboard.errors);
    if (scoreboard.errors == 0 && scoreboard.outstanding() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== exp_neg_taylor_series_core.f =====
src/ents_pkg.sv
src/ents_sequencer.sv
src/ents_datapath.sv
src/exp_neg_taylor_series_core.sv
dv/tb.sv
